/* rtl/dsa_pkg.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dsa_pkg;

    localparam int SLOTS    = 1024;
    localparam int KEY_BITS = 64;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ENTRY_W = KEY_BITS + 1;

    localparam int FIELD_SLOT_W = 10;
    localparam int FIELD_KEY_W  = 64;

    localparam int IN_DATA_W  = 80;
    localparam int IN_USER_W  = 1;
    localparam int OUT_DATA_W = 80;
    localparam int OUT_USER_W = 3;

    typedef enum logic [0:0] {
        ACT_CREATE  = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_REUSED   = 2'd1,
        ST_FULL     = 2'd2,
        ST_RELEASED = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic scan;
        logic finish;
    } dsa_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_release;
        logic scan_done;
        logic out_free;
    } dsa_stat_t;

endpackage

/* rtl/dsa_ram.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module dsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/dsa_ctrl.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator controller
// Sequences the clearing pass, request load, table scan and result write.
// ----------------------------------------------------------------------------
module dsa_ctrl
    import dsa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dsa_stat_t stat,
    output dsa_cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (stat.clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = stat.is_release ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_FINISH:
            begin
                cmd.finish = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/dsa_datapath.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator datapath
// Request registers, slot table, scan counter, search hint and result register.
// ----------------------------------------------------------------------------
module dsa_datapath
    import dsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dsa_cmd_t              cmd,
    output dsa_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic [OUT_USER_W-1:0] m_tuser
);

    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(SLOTS);
    localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(SLOTS - 1);

    logic                    req_release_reg;
    logic [KEY_BITS-1:0]     req_key_reg;
    logic [FIELD_SLOT_W-1:0] req_slot_reg;

    logic [CNT_W-1:0]  addr_reg,       addr_next;
    logic [CNT_W-1:0]  hint_reg,       hint_next;
    logic              rd_valid_reg,   rd_valid_next;
    logic [SLOT_W-1:0] rd_idx_reg;
    logic              match_reg,      match_next;
    logic [SLOT_W-1:0] match_idx_reg;
    logic              free_found_reg, free_found_next;
    logic [SLOT_W-1:0] free_idx_reg;

    logic                    out_valid_reg, out_valid_next;
    logic [FIELD_SLOT_W-1:0] out_slot_reg;
    status_t                 out_status_reg;
    logic                    out_write_reg;
    logic [FIELD_KEY_W-1:0]  out_key_reg;

    logic               ram_we;
    logic [SLOT_W-1:0]  ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    logic [ENTRY_W-1:0] ram_rd_data;

    logic              entry_used;
    logic              eval;
    logic              hit;
    logic              free_hit;
    logic              rel_in_range;
    logic [SLOT_W-1:0] rel_idx;

    logic [FIELD_SLOT_W-1:0] res_slot;
    status_t                 res_status;
    logic                    res_write;
    logic [FIELD_KEY_W-1:0]  res_key;

    dsa_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_table (
        .clk    (clk),
        .we     (ram_we),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(addr_reg[SLOT_W-1:0]),
        .rd_data(ram_rd_data)
    );

    assign entry_used   = ram_rd_data[KEY_BITS];
    assign ram_rd_en    = cmd.scan && !match_reg && (addr_reg != SLOTS_CNT);
    assign eval         = cmd.scan && rd_valid_reg && !match_reg;
    assign hit          = eval && entry_used && (ram_rd_data[KEY_BITS-1:0] == req_key_reg);
    assign free_hit     = eval && !entry_used && !free_found_reg
                          && (CNT_W'(rd_idx_reg) >= hint_reg);
    assign rel_in_range = 32'(req_slot_reg) < 32'(SLOTS);
    assign rel_idx      = SLOT_W'(req_slot_reg);

    assign stat.clear_done = (addr_reg == LAST_CNT);
    assign stat.is_release = (action_t'(s_tuser[0]) == ACT_RELEASE);
    assign stat.scan_done  = match_reg || ((addr_reg == SLOTS_CNT) && !rd_valid_reg);
    assign stat.out_free   = !out_valid_reg || m_tready;

    always_comb
    begin
        res_slot   = '0;
        res_status = ST_FULL;
        res_write  = 1'b0;
        res_key    = '0;
        if (req_release_reg)
        begin
            res_slot   = req_slot_reg;
            res_status = ST_RELEASED;
            res_write  = rel_in_range;
        end
        else if (match_reg)
        begin
            res_slot   = FIELD_SLOT_W'(match_idx_reg);
            res_status = ST_REUSED;
        end
        else if (free_found_reg)
        begin
            res_slot   = FIELD_SLOT_W'(free_idx_reg);
            res_status = ST_NEW;
            res_write  = 1'b1;
            res_key    = FIELD_KEY_W'(req_key_reg);
        end
    end

    always_comb
    begin
        ram_we      = 1'b0;
        ram_wr_addr = addr_reg[SLOT_W-1:0];
        ram_wr_data = '0;
        if (cmd.clear)
        begin
            ram_we = 1'b1;
        end
        else if (cmd.finish && res_write)
        begin
            ram_we = 1'b1;
            if (req_release_reg)
            begin
                ram_wr_addr = rel_idx;
            end
            else
            begin
                ram_wr_addr = free_idx_reg;
                ram_wr_data = {1'b1, req_key_reg};
            end
        end
    end

    always_comb
    begin
        addr_next       = addr_reg;
        hint_next       = hint_reg;
        rd_valid_next   = rd_valid_reg;
        match_next      = match_reg;
        free_found_next = free_found_reg;
        if (cmd.clear)
        begin
            addr_next = addr_reg + 1'b1;
        end
        if (cmd.load)
        begin
            addr_next       = '0;
            rd_valid_next   = 1'b0;
            match_next      = 1'b0;
            free_found_next = 1'b0;
        end
        if (cmd.scan)
        begin
            rd_valid_next = ram_rd_en;
            if (ram_rd_en)
            begin
                addr_next = addr_reg + 1'b1;
            end
            if (hit)
            begin
                match_next = 1'b1;
            end
            if (free_hit)
            begin
                free_found_next = 1'b1;
            end
        end
        if (cmd.finish && res_write)
        begin
            if (req_release_reg)
            begin
                if (CNT_W'(rel_idx) < hint_reg)
                begin
                    hint_next = CNT_W'(rel_idx);
                end
            end
            else
            begin
                hint_next = CNT_W'(free_idx_reg) + 1'b1;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg       <= '0;
            hint_reg       <= '0;
            rd_valid_reg   <= 1'b0;
            match_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            addr_reg       <= addr_next;
            hint_reg       <= hint_next;
            rd_valid_reg   <= rd_valid_next;
            match_reg      <= match_next;
            free_found_reg <= free_found_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_release_reg <= (action_t'(s_tuser[0]) == ACT_RELEASE);
            req_key_reg     <= s_tdata[KEY_BITS-1:0];
            req_slot_reg    <= s_tdata[FIELD_KEY_W +: FIELD_SLOT_W];
        end
        if (ram_rd_en)
        begin
            rd_idx_reg <= addr_reg[SLOT_W-1:0];
        end
        if (hit)
        begin
            match_idx_reg <= rd_idx_reg;
        end
        if (free_hit)
        begin
            free_idx_reg <= rd_idx_reg;
        end
        if (cmd.finish)
        begin
            out_slot_reg   <= res_slot;
            out_status_reg <= res_status;
            out_write_reg  <= res_write;
            out_key_reg    <= res_key;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_DATA_W - FIELD_KEY_W - FIELD_SLOT_W)'(0), out_key_reg, out_slot_reg};
    assign m_tuser  = {out_write_reg, out_status_reg};

endmodule

/* rtl/dedup_slot_allocator_core.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator core
// Hands out the lowest free slot for a descriptor key and reuses a slot that
// already holds an equal key; releases free a slot again.
// ----------------------------------------------------------------------------
// Requests enter on the s_ group and one result word per request leaves on
// the m_ group. A create reads every slot of the table RAM once, one entry per
// cycle through its single read port, and stops early on a key match; a
// release skips the scan. One request is in work at a time; s_tready rises
// again as soon as the result sits in the output register. After reset a
// clearing pass marks every slot free, one slot per cycle, and s_tready stays
// low until the pass is done. While the receiver holds m_tready low, the
// result word is held; the next request may still be accepted and worked on,
// and it waits at its end until the output register has been emptied.
// ----------------------------------------------------------------------------
module dedup_slot_allocator_core
    import dsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // desc_key [63:0], release_slot [73:64], zero [79:74]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // action [0]
    input  logic [IN_USER_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // slot_out [9:0], written_key [73:10], zero [79:74]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // status [1:0], table_write [2]
    output logic [OUT_USER_W-1:0] m_tuser
);

    dsa_cmd_t  cmd;
    dsa_stat_t stat;

    dsa_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    dsa_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .stat    (stat),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

/* tb/dedup_slot_allocator_core_tb.sv */
// ----------------------------------------------------------------------------
// Dedup slot allocator core testbench
// Drives create and release requests into the request stream and checks every
// result word against a predictor of the slot table kept in a scoreboard. A
// short directed run covers key extremes, reuse, release of free slots and the
// full table; a fill pass takes the table to capacity, then a random mix of
// requests runs with random idling on both streams, one long receiver stall
// and one sender pause until all results are back.
// ----------------------------------------------------------------------------
module dedup_slot_allocator_core_tb;
    import dsa_pkg::*;

    localparam int CYCLE_LIMIT   = 8_000_000;
    localparam int RANDOM_ITEMS  = 450;
    localparam int CHUNK_ITEMS   = 75;
    localparam int PAD_W         = IN_DATA_W - FIELD_SLOT_W - FIELD_KEY_W;

    typedef struct packed {
        logic [FIELD_SLOT_W-1:0] slot;
        status_t                 status;
        logic                    table_write;
        logic [FIELD_KEY_W-1:0]  written_key;
    } alloc_result_t;

    class slot_scoreboard;
        bit                  used [SLOTS];
        logic [KEY_BITS-1:0] key_of [SLOTS];
        int unsigned         hint;
        int unsigned         used_count;
        int unsigned         mismatches;
        alloc_result_t       expected_words [$];

        function new();
            foreach (used[i])
            begin
                used[i]   = 1'b0;
                key_of[i] = '0;
            end
            hint       = 0;
            used_count = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function int random_used_slot();
            int base;
            base = $urandom_range(SLOTS - 1);
            for (int i = 0; i < SLOTS; i++)
            begin
                if (used[(base + i) % SLOTS])
                    return (base + i) % SLOTS;
            end
            return base;
        endfunction

        function void note_input(action_t act, logic [FIELD_KEY_W-1:0] key_in,
                                 logic [FIELD_SLOT_W-1:0] slot_in);
            alloc_result_t       r;
            logic [KEY_BITS-1:0] key;
            bit                  found;
            int                  idx;
            r.slot        = '0;
            r.status      = ST_FULL;
            r.table_write = 1'b0;
            r.written_key = '0;
            if (act == ACT_CREATE)
            begin
                key   = key_in[KEY_BITS-1:0];
                found = 1'b0;
                for (int i = 0; i < SLOTS && !found; i++)
                begin
                    if (used[i] && key_of[i] == key)
                    begin
                        found    = 1'b1;
                        r.slot   = FIELD_SLOT_W'(i);
                        r.status = ST_REUSED;
                    end
                end
                for (int i = hint; i < SLOTS && !found; i++)
                begin
                    if (!used[i])
                    begin
                        found         = 1'b1;
                        used[i]       = 1'b1;
                        key_of[i]     = key;
                        hint          = i + 1;
                        used_count++;
                        r.slot        = FIELD_SLOT_W'(i);
                        r.status      = ST_NEW;
                        r.table_write = 1'b1;
                        r.written_key = key;
                    end
                end
            end
            else
            begin
                idx      = int'(slot_in);
                r.slot   = slot_in;
                r.status = ST_RELEASED;
                if (idx < SLOTS)
                begin
                    if (used[idx])
                        used_count--;
                    used[idx]     = 1'b0;
                    key_of[idx]   = '0;
                    if (idx < hint)
                        hint = idx;
                    r.table_write = 1'b1;
                end
            end
            expected_words.push_back(r);
        endfunction

        function void check_result(logic [FIELD_SLOT_W-1:0] slot, logic [1:0] status,
                                   logic table_write, logic [FIELD_KEY_W-1:0] written_key);
            alloc_result_t e;
            if (expected_words.size() == 0)
            begin
                $error("unexpected result word: slot_out %0d status %0d", slot, status);
                mismatches++;
                return;
            end
            e = expected_words.pop_front();
            if (slot !== e.slot)
            begin
                $error("slot_out: expected %0d, got %0d", e.slot, slot);
                mismatches++;
            end
            if (status !== e.status)
            begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (table_write !== e.table_write)
            begin
                $error("table_write: expected %0b, got %0b", e.table_write, table_write);
                mismatches++;
            end
            if (written_key !== e.written_key)
            begin
                $error("written_key: expected %h, got %h", e.written_key, written_key);
                mismatches++;
            end
        endfunction
    endclass

    logic                  clk      = 1'b0;
    logic                  rst_n    = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata  = '0;
    logic [IN_USER_W-1:0]  s_tuser  = ACT_CREATE;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [OUT_USER_W-1:0] m_tuser;

    slot_scoreboard sb = new();

    int unsigned src_idle_pct  = 20;
    int unsigned sink_idle_pct = 20;
    int unsigned sink_hold     = 0;
    int unsigned cycle_count   = 0;

    dedup_slot_allocator_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata[FIELD_SLOT_W-1:0], m_tuser[1:0], m_tuser[2],
                                m_tdata[FIELD_SLOT_W +: FIELD_KEY_W]);
            if (sink_hold > 0)
            begin
                m_tready <= 1'b0;
                sink_hold--;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk) cycle_count++;
        $display("FAIL dedup_slot_allocator_core");
        $finish;
    end

    task automatic send_request(input action_t act, input logic [FIELD_KEY_W-1:0] key,
                                input logic [FIELD_SLOT_W-1:0] slot);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {{PAD_W{1'b0}}, slot, key};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(act, key, slot);
    endtask

    task automatic create_desc(input logic [FIELD_KEY_W-1:0] key);
        send_request(ACT_CREATE, key, FIELD_SLOT_W'($urandom));
    endtask

    task automatic release_slot_req(input int slot);
        send_request(ACT_RELEASE, {$urandom, $urandom}, FIELD_SLOT_W'(slot));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        create_desc(64'h0);
        create_desc({64{1'b1}});
        create_desc(64'h0);
        create_desc({64{1'b1}});
        create_desc(64'hA5A5_A5A5_A5A5_A5A5);
        release_slot_req(1);
        create_desc({64{1'b1}});
        release_slot_req(SLOTS - 1);
        release_slot_req(0);
        create_desc(64'h0);
        release_slot_req(2);
        release_slot_req(2);
        create_desc(64'h5A5A_5A5A_5A5A_5A5A);
        create_desc(64'h8000_0000_0000_0001);

        // Take the table to capacity with fresh keys.
        while (sb.used_count < SLOTS)
            create_desc({$urandom, $urandom});

        create_desc({$urandom, $urandom});
        create_desc(sb.key_of[SLOTS - 1]);
        release_slot_req(SLOTS - 1);
        create_desc({$urandom, $urandom});
        release_slot_req(512);
        release_slot_req(5);
        create_desc({$urandom, $urandom});
        create_desc({$urandom, $urandom});
        create_desc({$urandom, $urandom});

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % CHUNK_ITEMS == 0)
            begin
                src_idle_pct  = (n / CHUNK_ITEMS == 2) ? 0 : 20;
                sink_idle_pct = (n / CHUNK_ITEMS == 2) ? 0 : 20;
                if (n / CHUNK_ITEMS == 1)
                    sink_hold = 3 * (SLOTS + 8);
                if (n / CHUNK_ITEMS == 4)
                    wait_drained();
            end
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                if ($urandom_range(1) == 0 && sb.used_count > 0)
                    release_slot_req(sb.random_used_slot());
                else
                    release_slot_req($urandom_range(SLOTS - 1));
            end
            else if (pick < 65 && sb.used_count > 0)
                create_desc(sb.key_of[sb.random_used_slot()]);
            else if (pick < 75)
                create_desc(64'($urandom_range(15)));
            else
                create_desc({$urandom, $urandom});
        end

        wait_drained();
        repeat (SLOTS + 8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS dedup_slot_allocator_core");
        else
            $display("FAIL dedup_slot_allocator_core");
        $finish;
    end

endmodule
